// File: rtl/unsorted_list_table_assert.svh
// assertion macros used by the list table datapath
`ifndef UNSORTED_LIST_TABLE_ASSERT_SVH
`define UNSORTED_LIST_TABLE_ASSERT_SVH

// same-cycle implication, held off during reset
`define ULT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("unsorted list table: check failed");

// next-cycle implication, held off during reset
`define ULT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("unsorted list table: check failed");

`endif

// File: rtl/ult_pkg.sv
package ult_pkg;

   // fixed port widths
   localparam int OP_W     = 3;
   localparam int PORT_W   = 32;
   localparam int COUNT_W  = 5;
   localparam int STATUS_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_INSERT   = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE   = 3'd1;
   localparam logic [OP_W-1:0] OP_RETRIEVE = 3'd2;
   localparam logic [OP_W-1:0] OP_RESET    = 3'd3;
   localparam logic [OP_W-1:0] OP_NEXT     = 3'd4;
   localparam logic [OP_W-1:0] OP_EMPTY    = 3'd5;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
   localparam logic [STATUS_W-1:0] ST_END      = 2'd3;

   // datapath actions, one per cycle
   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_FULL,
      ACT_MISS,
      ACT_END,
      ACT_CUR_RESET,
      ACT_EMPTY,
      ACT_IDX_TOP,
      ACT_IDX_ZERO,
      ACT_IDX_CURSOR,
      ACT_SCAN_STEP,
      ACT_READ,
      ACT_READ_NEXT,
      ACT_MOVE_UP,
      ACT_MOVE_DN,
      ACT_INS_HEAD,
      ACT_HIT,
      ACT_DEL_DONE,
      ACT_GOT,
      ACT_PUSH
   } ult_act_type;

   typedef struct packed {
      ult_act_type act;
   } ult_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            count_zero;
      logic            full;
      logic            hit;
      logic            last;
      logic            idx_zero;
      logic            cursor_end;
      logic            rsp_busy;
   } ult_sts_type;

endpackage

// File: rtl/ult_ctrl.sv
module ult_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output ult_pkg::ult_cmd_type cmd,
   input  ult_pkg::ult_sts_type sts
);
   import ult_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_UP_RD,
      S_UP_WR,
      S_INS_HEAD,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_DN_RD,
      S_DN_WR,
      S_NEXT_RD,
      S_NEXT_CAP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      req_ready_ff, req_ready_in;

   // next state and datapath action
   always_comb begin
      state_in = state_ff;
      cmd.act  = ACT_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready_ff) begin
               cmd.act  = ACT_LOAD;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.op) inside
               OP_INSERT: begin
                  if (sts.full) begin
                     cmd.act  = ACT_FULL;
                     state_in = S_DONE;
                  end else if (sts.count_zero) begin
                     cmd.act  = ACT_INS_HEAD;
                     state_in = S_DONE;
                  end else begin
                     cmd.act  = ACT_IDX_TOP;
                     state_in = S_UP_RD;
                  end
               end
               OP_DELETE, OP_RETRIEVE: begin
                  if (sts.count_zero) begin
                     cmd.act  = ACT_MISS;
                     state_in = S_DONE;
                  end else begin
                     cmd.act  = ACT_IDX_ZERO;
                     state_in = S_SCAN_RD;
                  end
               end
               OP_RESET: begin
                  cmd.act  = ACT_CUR_RESET;
                  state_in = S_DONE;
               end
               OP_NEXT: begin
                  if (sts.cursor_end) begin
                     cmd.act  = ACT_END;
                     state_in = S_DONE;
                  end else begin
                     cmd.act  = ACT_IDX_CURSOR;
                     state_in = S_NEXT_RD;
                  end
               end
               OP_EMPTY: begin
                  cmd.act  = ACT_EMPTY;
                  state_in = S_DONE;
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end
         // open a slot at the front, moving entries up from the tail
         S_UP_RD: begin
            cmd.act  = ACT_READ;
            state_in = S_UP_WR;
         end
         S_UP_WR: begin
            cmd.act  = ACT_MOVE_UP;
            state_in = sts.idx_zero ? S_INS_HEAD : S_UP_RD;
         end
         S_INS_HEAD: begin
            cmd.act  = ACT_INS_HEAD;
            state_in = S_DONE;
         end
         // linear search from the newest entry
         S_SCAN_RD: begin
            cmd.act  = ACT_READ;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (sts.hit) begin
               cmd.act  = ACT_HIT;
               state_in = (sts.op == OP_RETRIEVE) ? S_DONE : S_DN_RD;
            end else if (sts.last) begin
               cmd.act  = ACT_MISS;
               state_in = S_DONE;
            end else begin
               cmd.act  = ACT_SCAN_STEP;
               state_in = S_SCAN_RD;
            end
         end
         // close the gap, moving entries down one place
         S_DN_RD: begin
            if (sts.last) begin
               cmd.act  = ACT_DEL_DONE;
               state_in = S_DONE;
            end else begin
               cmd.act  = ACT_READ_NEXT;
               state_in = S_DN_WR;
            end
         end
         S_DN_WR: begin
            cmd.act  = ACT_MOVE_DN;
            state_in = S_DN_RD;
         end
         // fetch the entry under the cursor
         S_NEXT_RD: begin
            cmd.act  = ACT_READ;
            state_in = S_NEXT_CAP;
         end
         S_NEXT_CAP: begin
            cmd.act  = ACT_GOT;
            state_in = S_DONE;
         end
         // hand the word over once the output register is free
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.act  = ACT_PUSH;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready_in = (state_in == S_IDLE);

   // state and registered ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_ready_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_ready_ff <= req_ready_in;
      end
   end

   assign req_ready = req_ready_ff;

endmodule

// File: rtl/ult_datapath.sv
`include "unsorted_list_table_assert.svh"

module ult_datapath #(
   parameter int LIST_DEPTH = 16,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [ult_pkg::OP_W-1:0]         req_op,
   input  logic [ult_pkg::PORT_W-1:0]       req_item,
   input  ult_pkg::ult_cmd_type             cmd,
   output ult_pkg::ult_sts_type             sts,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [ult_pkg::PORT_W-1:0]       rsp_item_out,
   output logic [ult_pkg::COUNT_W-1:0]      rsp_count,
   output logic [ult_pkg::STATUS_W-1:0]     rsp_status
);
   import ult_pkg::*;

   localparam int AW = $clog2(LIST_DEPTH);
   localparam int CW = $clog2(LIST_DEPTH + 1);

   // entry store, slot 0 newest
   logic [ITEM_WIDTH-1:0] mem_ff [LIST_DEPTH];

   logic [OP_W-1:0]       op_ff, op_in;
   logic [ITEM_WIDTH-1:0] item_ff, item_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         match_ff, match_in;
   logic [ITEM_WIDTH-1:0] rdata_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         cursor_ff, cursor_in;
   logic                  res_found_ff, res_found_in;
   logic [ITEM_WIDTH-1:0] res_item_ff, res_item_in;
   logic [STATUS_W-1:0]   res_status_ff, res_status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff;
   logic [PORT_W-1:0]     rsp_item_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic [63:0]           req_item_wide;
   logic [63:0]           res_item_wide;
   logic [CW+4:0]         count_wide;
   logic [AW-1:0]         idx_p1;
   logic [CW-1:0]         idx_p1_c;
   logic [CW-1:0]         count_p1;
   logic                  push;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;

   // width adaptation between ports and storage
   assign req_item_wide = 64'(req_item);
   assign res_item_wide = 64'(res_item_ff);
   assign count_wide    = (CW + 5)'(count_ff);

   assign idx_p1   = idx_ff + AW'(1);
   assign idx_p1_c = CW'(idx_ff) + CW'(1);
   assign count_p1 = count_ff + CW'(1);
   assign push     = (cmd.act == ACT_PUSH);

   // status back to the controller
   always_comb begin
      sts.op         = op_ff;
      sts.count_zero = (count_ff == '0);
      sts.full       = (count_ff == CW'(LIST_DEPTH));
      sts.hit        = (rdata_ff == item_ff);
      sts.last       = (idx_p1_c >= count_ff);
      sts.idx_zero   = (idx_ff == '0);
      sts.cursor_end = (cursor_ff >= count_ff);
      sts.rsp_busy   = rsp_valid_ff && !rsp_ready;
   end

   // memory port selection
   always_comb begin
      rd_en   = (cmd.act == ACT_READ) || (cmd.act == ACT_READ_NEXT);
      rd_addr = (cmd.act == ACT_READ_NEXT) ? idx_p1 : idx_ff;
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_data = rdata_ff;
      case (cmd.act)
         ACT_MOVE_UP: begin
            wr_en   = 1'b1;
            wr_addr = idx_p1;
         end
         ACT_MOVE_DN: begin
            wr_en   = 1'b1;
         end
         ACT_INS_HEAD: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = item_ff;
         end
         default: begin
            wr_en   = 1'b0;
         end
      endcase
   end

   // next values for the working registers
   always_comb begin
      op_in         = op_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      match_in      = match_ff;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      res_found_in  = res_found_ff;
      res_item_in   = res_item_ff;
      res_status_in = res_status_ff;
      unique case (cmd.act)
         ACT_LOAD: begin
            op_in         = req_op;
            item_in       = req_item_wide[ITEM_WIDTH-1:0];
            res_found_in  = 1'b0;
            res_item_in   = '0;
            res_status_in = ST_OK;
         end
         ACT_FULL:       res_status_in = ST_FULL;
         ACT_MISS:       res_status_in = ST_NOTFOUND;
         ACT_END:        res_status_in = ST_END;
         ACT_CUR_RESET:  cursor_in = '0;
         ACT_EMPTY: begin
            count_in  = '0;
            cursor_in = '0;
         end
         ACT_IDX_TOP:    idx_in = AW'(count_ff - CW'(1));
         ACT_IDX_ZERO:   idx_in = '0;
         ACT_IDX_CURSOR: idx_in = cursor_ff[AW-1:0];
         ACT_SCAN_STEP:  idx_in = idx_p1;
         ACT_MOVE_UP:    idx_in = idx_ff - AW'(1);
         ACT_MOVE_DN:    idx_in = idx_p1;
         ACT_INS_HEAD: begin
            count_in = count_p1;
            // cursor follows its entry unless it sits before the first one
            if (cursor_ff != '0 && cursor_ff < count_p1) begin
               cursor_in = cursor_ff + CW'(1);
            end
         end
         ACT_HIT: begin
            res_found_in = 1'b1;
            match_in     = idx_ff;
         end
         ACT_DEL_DONE: begin
            count_in = count_ff - CW'(1);
            if (cursor_ff > CW'(match_ff)) begin
               cursor_in = cursor_ff - CW'(1);
            end
         end
         ACT_GOT: begin
            res_item_in = rdata_ff;
            cursor_in   = cursor_ff + CW'(1);
         end
         default: begin
            op_in = op_ff;
         end
      endcase
   end

   // output register handshake
   always_comb begin
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // entry store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

   // list state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      match_ff      <= match_in;
      res_found_ff  <= res_found_in;
      res_item_ff   <= res_item_in;
      res_status_ff <= res_status_in;
      if (push) begin
         rsp_found_ff  <= res_found_ff;
         rsp_item_ff   <= res_item_wide[PORT_W-1:0];
         rsp_count_ff  <= count_wide[COUNT_W-1:0];
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_item_out = rsp_item_ff;
   assign rsp_count    = rsp_count_ff;
   assign rsp_status   = rsp_status_ff;

   // checks
   `ULT_ASSERT_IMP(a_cursor_in_list, clock, reset, 1'b1, cursor_ff <= count_ff)
   `ULT_ASSERT_IMP(a_push_when_free, clock, reset, push, !(rsp_valid_ff && !rsp_ready))
   `ULT_ASSERT_NXT(a_push_shows_word, clock, reset, push, rsp_valid_ff)
   `ULT_ASSERT_NXT(a_insert_counts, clock, reset, cmd.act == ACT_INS_HEAD,
                   count_ff == $past(count_ff) + CW'(1))

endmodule

// File: rtl/unsorted_list_table.sv
// channel   ports                                                           direction
// req       req_valid req_ready req_op req_item                             in
// rsp       rsp_valid rsp_ready rsp_found rsp_item_out rsp_count rsp_status out
//
// one word is worked on at a time; entries move through the entry store, each one
// read and then written back one place over: a non-full insert moves every entry up
// before writing slot 0, delete scans from the newest entry and closes the gap,
// retrieve scans only, and get next reads the entry under the cursor
// reset is synchronous and active high and empties the list at once
// a stalled result holds in the output register; the next word is accepted meanwhile
module unsorted_list_table #(
   parameter int LIST_DEPTH = 16,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ult_pkg::OP_W-1:0]     req_op,
   input  logic [ult_pkg::PORT_W-1:0]   req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_found,
   output logic [ult_pkg::PORT_W-1:0]   rsp_item_out,
   output logic [ult_pkg::COUNT_W-1:0]  rsp_count,
   output logic [ult_pkg::STATUS_W-1:0] rsp_status
);
   import ult_pkg::*;

   ult_cmd_type cmd;
   ult_sts_type sts;

   // sequencer
   ult_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // entry store, list state and output register
   ult_datapath #(
      .LIST_DEPTH (LIST_DEPTH),
      .ITEM_WIDTH (ITEM_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_op       (req_op),
      .req_item     (req_item),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_found    (rsp_found),
      .rsp_item_out (rsp_item_out),
      .rsp_count    (rsp_count),
      .rsp_status   (rsp_status)
   );

endmodule
